@@ rtl/core/uvst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvst_pkg: shared types and constants of the UV sphere tessellator
// Phase codes, command and result records, sine table builder, saturation.
// ----------------------------------------------------------------------------
package uvst_pkg;

    localparam int MAX_SEGMENTS    = 256;
    localparam int ANGLE_BITS      = 12;
    localparam int SINE_DEPTH      = 1024;
    localparam int COORD_FRAC_BITS = 8;

    localparam int SEG_W   = 9;
    localparam int COORD_W = 16;
    localparam int RAD_W   = 15;
    localparam int IDX_W   = 16;
    localparam int TAB_AW  = $clog2(SINE_DEPTH + 1);
    localparam int DIVD_W  = SEG_W + ANGLE_BITS;   // dividend of the angle divide

    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    // configuration register indexes
    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_RADIUS   = 3'd3;
    localparam logic [2:0] REG_LON_SEG  = 3'd4;
    localparam logic [2:0] REG_LAT_SEG  = 3'd5;

    localparam logic ITEM_VERTEX   = 1'b0;
    localparam logic ITEM_TRIANGLE = 1'b1;

    typedef enum logic [2:0] {
        PH_TOP    = 3'd0,
        PH_RING   = 3'd1,
        PH_BOTTOM = 3'd2,
        PH_TOPFAN = 3'd3,
        PH_BAND   = 3'd4,
        PH_BOTFAN = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_NORM,
        F_ISSUE
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_ADDR,
        B_MUL,
        B_RND,
        B_EMIT
    } back_state_t;

    // factor being worked in the back end
    typedef enum logic [1:0] {
        FAC_RING_RAD = 2'd0,
        FAC_RING_HGT = 2'd1,
        FAC_POS_X    = 2'd2,
        FAC_POS_Z    = 2'd3
    } factor_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [RAD_W-1:0]          radius;
        logic [SEG_W-1:0]          lon_seg;
        logic [SEG_W-1:0]          lat_seg;
    } cfg_t;

    typedef struct packed {
        logic                      item_kind;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [IDX_W-1:0]          index_a;
        logic [IDX_W-1:0]          index_b;
        logic [IDX_W-1:0]          index_c;
        logic                      bad_config;
        logic                      last_item;
    } res_t;

    typedef struct packed {
        logic             ring_vtx;  // needs the back end arithmetic
        logic             new_ring;  // reload ring radius and height first
        logic [SEG_W:0]   ring1;     // 1-based ring number
        logic [SEG_W-1:0] lon;
        res_t             res;       // finished result when not a ring vertex
    } cmd_t;

    typedef logic [16:0] sine_tab_t [0:SINE_DEPTH];

    localparam longint unsigned TAYLOR_DIV [1:9] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342};

    // Q1.15 quarter-wave sine, evaluated at elaboration only
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t       tab;
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          q;
        for (int i = 0; i <= SINE_DEPTH; i++) begin
            x    = (PI_HALF_Q30 * longint'(i)) / SINE_DEPTH;
            sum  = longint'(x);
            term = x;
            for (int n = 1; n <= 9; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / TAYLOR_DIV[n];
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            q = (sum + 16384) >>> 15;
            if (q > 32768)
                q = 32768;
            tab[i] = q[16:0];
        end
        return tab;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767)
            return 16'sh7fff;
        else if (v < -19'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/uv_sphere_tessellator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uv_sphere_tessellator: UV sphere vertex and index stream generator
// Each request transfer yields one result: a vertex or a triangle.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_ready, restart): each transfer asks for the
//   next item; restart = 1 starts over at the top pole.
//   Result channel (out_valid/out_ready): one result per request, in order.
//   Order: top pole, inner rings top to bottom, bottom pole, top cap fan,
//   band quads (two triangles each), bottom cap fan; last_item marks the end.
//   Bad segment counts make each request give an error result with bad_config set.
//   Config port (cfg_we, cfg_index, cfg_data): write only while idle.
// Processing:
//   The front sequencer takes one request at a time (plus one step per wrap of
//   a stale column count). Poles and triangles pass from the two-entry queue
//   through a result register into the output register.
//   A ring vertex costs one angle divide plus two sine lookups and scale
//   steps; the first vertex of a ring adds a second divide and two more
//   scale steps.
// Reset: the sequence restarts at the top pole, config goes to its defaults.
// Stall: a held result waits in the output register; the queue keeps taking
//   requests until it fills, then in_ready drops.
// ----------------------------------------------------------------------------
module uv_sphere_tessellator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        restart,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             item_kind,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic signed [15:0] pos_z,
    output logic [15:0]      index_a,
    output logic [15:0]      index_b,
    output logic [15:0]      index_c,
    output logic             bad_config,
    output logic             last_item
);
    import uvst_pkg::*;

    cfg_t cfg_reg;
    cmd_t push_cmd;
    cmd_t head_cmd;
    res_t res;
    logic q_push, q_pop, q_full, q_empty;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x <= '0;
            cfg_reg.center_y <= '0;
            cfg_reg.center_z <= '0;
            cfg_reg.radius   <= RAD_W'(1 << COORD_FRAC_BITS);
            cfg_reg.lon_seg  <= SEG_W'(16);
            cfg_reg.lat_seg  <= SEG_W'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X: cfg_reg.center_x <= cfg_data;
                REG_CENTER_Y: cfg_reg.center_y <= cfg_data;
                REG_CENTER_Z: cfg_reg.center_z <= cfg_data;
                REG_RADIUS:   cfg_reg.radius   <= cfg_data[RAD_W-1:0];
                REG_LON_SEG:  cfg_reg.lon_seg  <= cfg_data[SEG_W-1:0];
                REG_LAT_SEG:  cfg_reg.lat_seg  <= cfg_data[SEG_W-1:0];
                default:      ;
            endcase
        end
    end

    // front: sequencing and index math
    uvst_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .restart  (restart),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    uvst_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back: ring vertex arithmetic, output register
    uvst_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (head_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res)
    );

    assign item_kind  = res.item_kind;
    assign pos_x      = res.pos_x;
    assign pos_y      = res.pos_y;
    assign pos_z      = res.pos_z;
    assign index_a    = res.index_a;
    assign index_b    = res.index_b;
    assign index_c    = res.index_c;
    assign bad_config = res.bad_config;
    assign last_item  = res.last_item;

endmodule
`default_nettype wire

@@ rtl/core/uvst_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvst_div: iterative restoring divider
// One quotient bit per cycle; quotient valid on the cycle done is high.
// ----------------------------------------------------------------------------
module uvst_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [uvst_pkg::DIVD_W-1:0] dividend,
    input  wire logic [uvst_pkg::SEG_W-1:0]  divisor,
    output logic                             done,
    output logic [uvst_pkg::DIVD_W-1:0]      quotient
);
    import uvst_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SEG_W-1:0]  rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [SEG_W-1:0]  div_reg, div_next;
    logic [SEG_W:0]    trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[DIVD_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVD_W);
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = SEG_W'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[SEG_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

@@ rtl/core/uvst_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvst_fifo: two-entry command queue
// Decouples the sequencer front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module uvst_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire uvst_pkg::cmd_t  push_cmd,
    input  wire logic            pop,
    output uvst_pkg::cmd_t       head_cmd,
    output logic                 full,
    output logic                 empty
);
    import uvst_pkg::*;

    cmd_t       mem_reg [0:1];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    assign head_cmd = mem_reg[rd_ptr_reg];
    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);

endmodule
`default_nettype wire

@@ rtl/core/uvst_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvst_front: request sequencer
// Walks the vertex and triangle order, builds poles, triangles and errors,
// and hands ring vertices to the back end as commands.
// ----------------------------------------------------------------------------
module uvst_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire uvst_pkg::cfg_t cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           restart,
    input  wire logic           q_full,
    output logic                q_push,
    output uvst_pkg::cmd_t      q_cmd
);
    import uvst_pkg::*;

    front_state_t     state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [SEG_W-1:0] ring_reg, ring_next;
    logic [SEG_W-1:0] lon_reg, lon_next;
    logic             half_reg, half_next;
    logic [SEG_W-1:0] j_reg, j_next;

    logic             bad;
    logic [SEG_W-1:0] rings;
    logic [SEG_W:0]   lon_inc, ring_inc, ring_inc2, j_inc;
    logic [SEG_W-1:0] jn;
    logic [SEG_W-1:0] mop;
    logic [2*SEG_W-1:0] prod;
    logic [18:0]      rs, ns, bot;
    logic             phase_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            phase_reg <= PH_TOP;
            ring_reg  <= '0;
            lon_reg   <= '0;
            half_reg  <= 1'b0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            ring_reg  <= ring_next;
            lon_reg   <= lon_next;
            half_reg  <= half_next;
            j_reg     <= j_next;
        end
    end

    always_comb
    begin
        bad = (cfg.lon_seg < SEG_W'(3)) || (cfg.lat_seg < SEG_W'(2))
            || ({1'b0, cfg.lon_seg} > (SEG_W+1)'(MAX_SEGMENTS))
            || ({1'b0, cfg.lat_seg} > (SEG_W+1)'(MAX_SEGMENTS));
        rings     = cfg.lat_seg - 1'b1;
        lon_inc   = {1'b0, lon_reg} + 1'b1;
        ring_inc  = {1'b0, ring_reg} + 1'b1;
        ring_inc2 = {1'b0, ring_reg} + 2'd2;
        j_inc     = {1'b0, j_reg} + 1'b1;
        jn        = (j_inc == {1'b0, cfg.lon_seg}) ? '0 : j_inc[SEG_W-1:0];
        mop       = (phase_reg == PH_BAND) ? ring_reg : (rings - 1'b1);
        prod      = mop * cfg.lon_seg;
        rs        = 19'(prod) + 19'd1;
        ns        = rs + 19'(cfg.lon_seg);
        bot       = ns;
        phase_ok  = (phase_reg == PH_TOP) || (phase_reg == PH_RING)
                 || (phase_reg == PH_BOTTOM) || (phase_reg == PH_TOPFAN)
                 || (phase_reg == PH_BAND) || (phase_reg == PH_BOTFAN);

        state_next = state_reg;
        phase_next = phase_reg;
        ring_next  = ring_reg;
        lon_next   = lon_reg;
        half_next  = half_reg;
        j_next     = j_reg;
        in_ready   = 1'b0;
        q_push     = 1'b0;
        q_cmd      = '0;

        case (state_reg)
            F_IDLE:
            begin
                in_ready = !q_full;
                if (in_valid && !q_full)
                begin
                    j_next = lon_reg;
                    if (restart || !phase_ok)
                    begin
                        phase_next = PH_TOP;
                        ring_next  = '0;
                        lon_next   = '0;
                        half_next  = 1'b0;
                        j_next     = '0;
                    end
                    state_next = F_NORM;
                end
            end
            F_NORM:
            begin
                // column index modulo the segment count
                if (!bad && (j_reg >= cfg.lon_seg))
                    j_next = j_reg - cfg.lon_seg;
                else
                    state_next = F_ISSUE;
            end
            F_ISSUE:
            begin
                q_push     = 1'b1;
                state_next = F_IDLE;
                if (bad)
                begin
                    q_cmd.res.bad_config = 1'b1;
                    q_cmd.res.last_item  = 1'b1;
                    phase_next = PH_TOP;
                    ring_next  = '0;
                    lon_next   = '0;
                    half_next  = 1'b0;
                end
                else
                begin
                    case (phase_reg)
                        PH_RING:
                        begin
                            q_cmd.ring_vtx = 1'b1;
                            q_cmd.new_ring = (lon_reg == '0);
                            q_cmd.ring1    = ring_inc;
                            q_cmd.lon      = lon_reg;
                            lon_next = lon_inc[SEG_W-1:0];
                            if (lon_inc >= {1'b0, cfg.lon_seg})
                            begin
                                lon_next  = '0;
                                ring_next = ring_inc[SEG_W-1:0];
                                if (ring_inc >= {1'b0, rings})
                                    phase_next = PH_BOTTOM;
                            end
                        end
                        PH_BOTTOM:
                        begin
                            q_cmd.res.item_kind = ITEM_VERTEX;
                            q_cmd.res.pos_x = cfg.center_x;
                            q_cmd.res.pos_y = sat16(19'(cfg.center_y) - 19'(cfg.radius));
                            q_cmd.res.pos_z = cfg.center_z;
                            phase_next = PH_TOPFAN;
                            lon_next   = '0;
                        end
                        PH_TOPFAN:
                        begin
                            q_cmd.res.item_kind = ITEM_TRIANGLE;
                            q_cmd.res.index_a   = '0;
                            q_cmd.res.index_b   = IDX_W'(jn) + 1'b1;
                            q_cmd.res.index_c   = IDX_W'(j_reg) + 1'b1;
                            lon_next = lon_inc[SEG_W-1:0];
                            if (lon_inc >= {1'b0, cfg.lon_seg})
                            begin
                                lon_next   = '0;
                                ring_next  = '0;
                                half_next  = 1'b0;
                                phase_next = (rings >= SEG_W'(2)) ? PH_BAND : PH_BOTFAN;
                            end
                        end
                        PH_BAND:
                        begin
                            q_cmd.res.item_kind = ITEM_TRIANGLE;
                            if (!half_reg)
                            begin
                                q_cmd.res.index_a = IDX_W'(rs + 19'(j_reg));
                                q_cmd.res.index_b = IDX_W'(rs + 19'(jn));
                                q_cmd.res.index_c = IDX_W'(ns + 19'(j_reg));
                                half_next = 1'b1;
                            end
                            else
                            begin
                                q_cmd.res.index_a = IDX_W'(rs + 19'(jn));
                                q_cmd.res.index_b = IDX_W'(ns + 19'(jn));
                                q_cmd.res.index_c = IDX_W'(ns + 19'(j_reg));
                                half_next = 1'b0;
                                lon_next  = lon_inc[SEG_W-1:0];
                                if (lon_inc >= {1'b0, cfg.lon_seg})
                                begin
                                    lon_next  = '0;
                                    ring_next = ring_inc[SEG_W-1:0];
                                    if (ring_inc2 >= {1'b0, rings})
                                        phase_next = PH_BOTFAN;
                                end
                            end
                        end
                        PH_BOTFAN:
                        begin
                            q_cmd.res.item_kind = ITEM_TRIANGLE;
                            q_cmd.res.index_a   = IDX_W'(rs + 19'(j_reg));
                            q_cmd.res.index_b   = IDX_W'(rs + 19'(jn));
                            q_cmd.res.index_c   = IDX_W'(bot);
                            lon_next = lon_inc[SEG_W-1:0];
                            if (lon_inc >= {1'b0, cfg.lon_seg})
                            begin
                                q_cmd.res.last_item = 1'b1;
                                lon_next   = '0;
                                ring_next  = '0;
                                half_next  = 1'b0;
                                phase_next = PH_TOP;
                            end
                        end
                        default:
                        begin
                            q_cmd.res.item_kind = ITEM_VERTEX;
                            q_cmd.res.pos_x = cfg.center_x;
                            q_cmd.res.pos_y = sat16(19'(cfg.center_y) + 19'(cfg.radius));
                            q_cmd.res.pos_z = cfg.center_z;
                            phase_next = PH_RING;
                            ring_next  = '0;
                            lon_next   = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/uvst_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvst_back: ring vertex arithmetic and output register
// Divides out the angles, looks up the sine table, scales and offsets.
// ----------------------------------------------------------------------------
module uvst_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire uvst_pkg::cfg_t cfg,
    input  wire logic           q_empty,
    input  wire uvst_pkg::cmd_t q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output uvst_pkg::res_t      out_res
);
    import uvst_pkg::*;

    localparam sine_tab_t SINE_TAB = build_sine_tab();
    localparam int QB = ANGLE_BITS - 2;

    back_state_t              state_reg, state_next;
    factor_t                  sel_reg, sel_next;
    logic                     out_valid_reg, out_valid_next;
    res_t                     out_res_reg, out_res_next;
    res_t                     res_reg, res_next;
    logic [SEG_W:0]           ring1_reg, ring1_next;
    logic [SEG_W-1:0]         lon_reg, lon_next;
    logic [ANGLE_BITS-1:0]    angle_reg, angle_next;
    logic [16:0]              rom_reg, rom_next;
    logic                     neg_reg, neg_next;
    logic signed [32:0]       prod_reg, prod_next;
    logic signed [15:0]       rr_reg, rr_next;
    logic signed [15:0]       rh_reg, rh_next;
    logic signed [15:0]       px_reg, px_next;

    logic                     div_start;
    logic [DIVD_W-1:0]        div_dividend;
    logic                     div_done;
    logic [DIVD_W-1:0]        div_quotient;

    logic [ANGLE_BITS-1:0]    ang;
    logic [QB-1:0]            ang_p;
    logic [TAB_AW-1:0]        tab_idx;
    logic signed [17:0]       tval;
    logic signed [16:0]       mop;
    logic [32:0]              mag;
    logic [17:0]              rnd;
    logic signed [18:0]       val;

    uvst_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  ((sel_next == FAC_RING_RAD) ? cfg.lat_seg : cfg.lon_seg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg     <= sel_next;
        out_res_reg <= out_res_next;
        res_reg     <= res_next;
        ring1_reg   <= ring1_next;
        lon_reg     <= lon_next;
        angle_reg   <= angle_next;
        rom_reg     <= rom_next;
        neg_reg     <= neg_next;
        prod_reg    <= prod_next;
        rr_reg      <= rr_next;
        rh_reg      <= rh_next;
        px_reg      <= px_next;
    end

    always_comb
    begin
        // cosine is the sine a quarter turn on
        ang   = angle_reg + (((sel_reg == FAC_RING_HGT) || (sel_reg == FAC_POS_X))
                ? ANGLE_BITS'(1 << QB) : '0);
        ang_p = ang[QB-1:0];
        tab_idx = TAB_AW'((TAB_AW+QB)'(ang_p) * SINE_DEPTH >> QB);
        if (ang[QB])
            tab_idx = TAB_AW'(SINE_DEPTH) - tab_idx;

        tval = neg_reg ? -$signed({1'b0, rom_reg}) : $signed({1'b0, rom_reg});
        mop  = (sel_reg == FAC_RING_RAD || sel_reg == FAC_RING_HGT)
             ? $signed({2'b00, cfg.radius}) : 17'(rr_reg);
        mag  = prod_reg[32] ? 33'(-prod_reg) : 33'(prod_reg);
        rnd  = 18'((34'(mag) + 34'd16384) >> 15);
        val  = prod_reg[32] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});

        state_next     = state_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_res_next   = out_res_reg;
        res_next       = res_reg;
        ring1_next     = ring1_reg;
        lon_next       = lon_reg;
        angle_next     = angle_reg;
        rom_next       = rom_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        rr_next        = rr_reg;
        rh_next        = rh_reg;
        px_next        = px_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        div_dividend   = {lon_reg, {ANGLE_BITS{1'b0}}};

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_head.ring_vtx)
                    begin
                        ring1_next = q_head.ring1;
                        lon_next   = q_head.lon;
                        div_start  = 1'b1;
                        if (q_head.new_ring)
                        begin
                            sel_next     = FAC_RING_RAD;
                            div_dividend = DIVD_W'({q_head.ring1, {(ANGLE_BITS-1){1'b0}}});
                        end
                        else
                        begin
                            sel_next     = FAC_POS_X;
                            div_dividend = {q_head.lon, {ANGLE_BITS{1'b0}}};
                        end
                        state_next = B_DIV;
                    end
                    else
                    begin
                        res_next   = q_head.res;
                        state_next = B_EMIT;
                    end
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    angle_next = div_quotient[ANGLE_BITS-1:0];
                    state_next = B_ADDR;
                end
            end
            B_ADDR:
            begin
                rom_next   = SINE_TAB[tab_idx];
                neg_next   = ang[QB+1];
                state_next = B_MUL;
            end
            B_MUL:
            begin
                prod_next  = 33'(tval * mop);
                state_next = B_RND;
            end
            B_RND:
            begin
                case (sel_reg)
                    FAC_RING_RAD:
                    begin
                        rr_next    = val[15:0];
                        sel_next   = FAC_RING_HGT;
                        state_next = B_ADDR;
                    end
                    FAC_RING_HGT:
                    begin
                        rh_next      = val[15:0];
                        sel_next     = FAC_POS_X;
                        div_start    = 1'b1;
                        div_dividend = {lon_reg, {ANGLE_BITS{1'b0}}};
                        state_next   = B_DIV;
                    end
                    FAC_POS_X:
                    begin
                        px_next    = sat16(19'(cfg.center_x) + val);
                        sel_next   = FAC_POS_Z;
                        state_next = B_ADDR;
                    end
                    default:
                    begin
                        res_next           = '0;
                        res_next.item_kind = ITEM_VERTEX;
                        res_next.pos_x     = px_reg;
                        res_next.pos_y     = sat16(19'(cfg.center_y) + 19'(rh_reg));
                        res_next.pos_z     = sat16(19'(cfg.center_z) + val);
                        state_next         = B_EMIT;
                    end
                endcase
            end
            B_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule
`default_nettype wire
